### hw/rtl/ffa_pkg.sv
`default_nettype none
package ffa_pkg;

  // Sizes of the managed memory and of the segment table.
  localparam int unsigned MEM_BYTES = 1024;
  localparam int unsigned MAX_SEG   = 64;
  localparam int unsigned TASK_BITS = 8;

  localparam int unsigned AW  = $clog2(MEM_BYTES);
  localparam int unsigned LW  = $clog2(MEM_BYTES + 1);
  localparam int unsigned WW  = LW + 1;
  localparam int unsigned SIW = $clog2(MAX_SEG);
  localparam int unsigned SCW = $clog2(MAX_SEG + 1);
  localparam int unsigned OW  = TASK_BITS + 1;

  // Fixed port field widths.
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned HDL_W  = 10;
  localparam int unsigned SIZE_W = 11;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned STS_W  = 3;
  localparam int unsigned DATA_W = 10;
  localparam int unsigned CFG_W  = 11;
  localparam int unsigned CIDX_W = 2;

  localparam logic [OW-1:0]     OWNER_NONE = {1'b1, {TASK_BITS{1'b0}}};
  localparam logic [BYTE_W-1:0] DOT_CHAR   = 8'h2E;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_PAGE  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_MSIZE = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_IBYTE = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT  = 3'd0,
    CMD_ALLOC = 3'd1,
    CMD_FREE  = 3'd2,
    CMD_RNEXT = 3'd3,
    CMD_WNEXT = 3'd4,
    CMD_RAT   = 3'd5,
    CMD_WAT   = 3'd6,
    CMD_STATS = 3'd7
  } cmd_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK        = 3'd0,
    STS_NO_HANDLE = 3'd1,
    STS_NOT_OWNER = 3'd2,
    STS_HOLDS     = 3'd3,
    STS_NO_SPACE  = 3'd4,
    STS_RANGE     = 3'd5,
    STS_BAD_CFG   = 3'd6
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_INIT_CHK, S_FILL, S_INIT_SEG,
    S_HOLD_RD, S_HOLD_CHK, S_ALLOC_CHK, S_WANT,
    S_FIT_RD, S_FIT_CHK, S_UP_RD, S_UP_WR, S_SPLIT_WR, S_TAKE_WR,
    S_FIND_RD, S_FIND_CHK, S_ACCESS, S_MEM_RD,
    S_PREV_RD, S_PREV_CHK, S_NEXT_RD, S_NEXT_CHK,
    S_MERGE_WR, S_DN_RD, S_DN_WR,
    S_DOT_RD, S_DOT_CHK, S_DOT_FILL,
    S_STAT_RD, S_STAT_CHK
  } state_e;

  // One segment table record.
  typedef struct packed {
    logic [AW-1:0] start;
    logic [LW-1:0] len;
    logic          alloc;
    logic [OW-1:0] owner;
    logic [LW-1:0] cursor;
  } seg_t;

  // One queued command beat.
  typedef struct packed {
    cmd_e                 cmd;
    logic [TASK_BITS-1:0] task_id;
    logic [HDL_W-1:0]     handle;
    logic [SIZE_W-1:0]    req_size;
    logic [HDL_W-1:0]     offset;
    logic [SIZE_W-1:0]    span;
    logic [BYTE_W-1:0]    byte_in;
  } item_t;

endpackage
`default_nettype wire

### hw/rtl/ffa_ram.sv
`default_nettype none
module ffa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### hw/rtl/ffa_front.sv
`default_nettype none
module ffa_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [ffa_pkg::CMD_W-1:0]       cmd_i,
  input  wire logic [ffa_pkg::TASK_BITS-1:0]   task_id_i,
  input  wire logic [ffa_pkg::HDL_W-1:0]       handle_i,
  input  wire logic [ffa_pkg::SIZE_W-1:0]      req_size_i,
  input  wire logic [ffa_pkg::HDL_W-1:0]       offset_i,
  input  wire logic [ffa_pkg::SIZE_W-1:0]      span_i,
  input  wire logic [ffa_pkg::BYTE_W-1:0]      byte_in_i,
  output logic                                 q_valid_o,
  output ffa_pkg::item_t                       q_item_o,
  input  wire logic                            q_pop_i
);

  ffa_pkg::item_t item_q [2];
  ffa_pkg::item_t new_item;
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           push;

  // Decode the command code and pack the beat.
  always_comb begin
    new_item.cmd      = ffa_pkg::cmd_e'(cmd_i);
    new_item.task_id  = task_id_i;
    new_item.handle   = handle_i;
    new_item.req_size = req_size_i;
    new_item.offset   = offset_i;
    new_item.span     = span_i;
    new_item.byte_in  = byte_in_i;
  end

  assign busy      = (count_q == 2'd2);
  assign push      = start && !busy;
  assign q_valid_o = (count_q != 2'd0);
  assign q_item_o  = item_q[rd_ptr_q];

  // Two-entry queue pointers.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (q_pop_i && q_valid_o) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push && !(q_pop_i && q_valid_o)) begin
      count_d = count_q + 2'd1;
    end else if (!push && q_pop_i && q_valid_o) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue payload storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      item_q[wr_ptr_q] <= new_item;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/ffa_back.sv
`default_nettype none
module ffa_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [ffa_pkg::CIDX_W-1:0]  cfg_idx_i,
  input  wire logic [ffa_pkg::CFG_W-1:0]   cfg_data_i,
  input  wire logic                        q_valid_i,
  input  wire ffa_pkg::item_t              q_item_i,
  output logic                             q_pop_o,
  output logic                             done_o,
  output logic [ffa_pkg::STS_W-1:0]        status_o,
  output logic [ffa_pkg::DATA_W-1:0]       data_out_o,
  output logic [ffa_pkg::SIZE_W-1:0]       free_total_o,
  output logic [ffa_pkg::SIZE_W-1:0]       largest_free_o,
  output logic [ffa_pkg::SIZE_W-1:0]       smallest_free_o
);

  localparam int unsigned AW  = ffa_pkg::AW;
  localparam int unsigned LW  = ffa_pkg::LW;
  localparam int unsigned WW  = ffa_pkg::WW;
  localparam int unsigned SIW = ffa_pkg::SIW;
  localparam int unsigned SCW = ffa_pkg::SCW;

  ffa_pkg::state_e  state_q, state_d;
  ffa_pkg::item_t   item_q, item_d;
  ffa_pkg::seg_t    ent_q, ent_d;
  ffa_pkg::seg_t    prev_q, prev_d;
  ffa_pkg::seg_t    rd;
  ffa_pkg::status_e status_q, status_d;
  logic [SCW-1:0]   n_q, n_d;
  logic [SCW-1:0]   idx_q, idx_d;
  logic [SCW-1:0]   found_q, found_d;
  logic [WW-1:0]    want_q, want_d;
  logic [LW-1:0]    cnt_q, cnt_d;
  logic [LW-1:0]    nxt_len_q, nxt_len_d;
  logic             has_prev_q, has_prev_d;
  logic             has_next_q, has_next_d;
  logic             done_q, done_d;
  logic [ffa_pkg::DATA_W-1:0] data_q, data_d;
  logic [LW-1:0]    ftot_q, ftot_d, large_q, large_d, small_q, small_d;
  logic [LW-1:0]    page_q, msize_q;
  logic [ffa_pkg::BYTE_W-1:0] ibyte_q;

  // Segment and byte memory ports.
  logic                            seg_we;
  logic [SIW-1:0]                  seg_waddr, seg_raddr;
  ffa_pkg::seg_t                   seg_wdata;
  logic [$bits(ffa_pkg::seg_t)-1:0] seg_rdata;
  logic                            mem_we;
  logic [AW-1:0]                   mem_waddr, mem_raddr;
  logic [ffa_pkg::BYTE_W-1:0]      mem_wdata, mem_rdata;

  // Shared conditions.
  logic           last_idx, fit_ok, split, owner_ok, cur_cmd, cur_end, at_bad;
  logic           bad_simple;
  logic [AW-1:0]  acc_addr;
  logic [SCW-1:0] base_idx;
  logic [1:0]     del;
  ffa_pkg::seg_t  merge_ent, split_ent, take_ent, cur_ent;

  ffa_ram #(.Width($bits(ffa_pkg::seg_t)), .Depth(ffa_pkg::MAX_SEG)) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (seg_we),
    .waddr_i (seg_waddr),
    .wdata_i (seg_wdata),
    .raddr_i (seg_raddr),
    .rdata_o (seg_rdata)
  );

  ffa_ram #(.Width(ffa_pkg::BYTE_W), .Depth(ffa_pkg::MEM_BYTES)) u_mem_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rd = ffa_pkg::seg_t'(seg_rdata);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q  <= LW'(16);
      msize_q <= LW'(ffa_pkg::MEM_BYTES);
      ibyte_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ffa_pkg::CFG_PAGE:  page_q  <= cfg_data_i;
        ffa_pkg::CFG_MSIZE: msize_q <= cfg_data_i;
        ffa_pkg::CFG_IBYTE: ibyte_q <= cfg_data_i[ffa_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Conditions shared by the sequencer blocks.
  always_comb begin
    last_idx   = (idx_q + SCW'(1)) >= n_q;
    fit_ok     = !rd.alloc && ({1'b0, rd.len} >= want_q);
    split      = {1'b0, rd.len} > want_q;
    owner_ok   = ent_q.alloc && (ent_q.owner == {1'b0, item_q.task_id});
    cur_cmd    = (item_q.cmd inside {ffa_pkg::CMD_RNEXT, ffa_pkg::CMD_WNEXT});
    cur_end    = ent_q.cursor >= ent_q.len;
    at_bad     = ({2'b0, item_q.offset} >= {1'b0, ent_q.len}) ||
                 (({2'b0, item_q.offset} + {1'b0, item_q.span}) > {1'b0, ent_q.len});
    acc_addr   = cur_cmd ? ent_q.start + ent_q.cursor[AW-1:0]
                         : ent_q.start + AW'(item_q.offset);
    bad_simple = (page_q == '0) || (msize_q == '0) || (page_q > msize_q) ||
                 (msize_q > LW'(ffa_pkg::MEM_BYTES));
    base_idx   = has_prev_q ? found_q - SCW'(1) : found_q;
    del        = {1'b0, has_prev_q} + {1'b0, has_next_q};

    merge_ent.start  = has_prev_q ? prev_q.start : ent_q.start;
    merge_ent.len    = (has_prev_q ? prev_q.len : '0) + ent_q.len +
                       (has_next_q ? nxt_len_q : '0);
    merge_ent.alloc  = 1'b0;
    merge_ent.owner  = ffa_pkg::OWNER_NONE;
    merge_ent.cursor = '0;

    split_ent.start  = ent_q.start + want_q[AW-1:0];
    split_ent.len    = ent_q.len - want_q[LW-1:0];
    split_ent.alloc  = 1'b0;
    split_ent.owner  = ffa_pkg::OWNER_NONE;
    split_ent.cursor = '0;

    take_ent.start   = ent_q.start;
    take_ent.len     = want_q[LW-1:0];
    take_ent.alloc   = 1'b1;
    take_ent.owner   = {1'b0, item_q.task_id};
    take_ent.cursor  = '0;

    cur_ent          = ent_q;
    cur_ent.cursor   = cur_end ? '0 : ent_q.cursor + LW'(1);
  end

  // Datapath and memory control of the sequencer.
  always_comb begin
    item_d     = item_q;
    ent_d      = ent_q;
    prev_d     = prev_q;
    status_d   = status_q;
    n_d        = n_q;
    idx_d      = idx_q;
    found_d    = found_q;
    want_d     = want_q;
    cnt_d      = cnt_q;
    nxt_len_d  = nxt_len_q;
    has_prev_d = has_prev_q;
    has_next_d = has_next_q;
    data_d     = data_q;
    ftot_d     = ftot_q;
    large_d    = large_q;
    small_d    = small_q;
    done_d     = 1'b0;
    q_pop_o    = 1'b0;
    seg_we     = 1'b0;
    seg_waddr  = found_q[SIW-1:0];
    seg_wdata  = take_ent;
    seg_raddr  = idx_q[SIW-1:0];
    mem_we     = 1'b0;
    mem_waddr  = acc_addr;
    mem_wdata  = item_q.byte_in;
    mem_raddr  = acc_addr;

    case (state_q)
      ffa_pkg::S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
        end
      end
      ffa_pkg::S_DISP: begin
        ftot_d   = '0;
        large_d  = '0;
        small_d  = '0;
        data_d   = '0;
        status_d = ffa_pkg::STS_OK;
        idx_d    = '0;
        want_d   = '0;
        cnt_d    = '0;
        case (item_q.cmd)
          ffa_pkg::CMD_INIT: begin
            if (bad_simple) begin
              done_d   = 1'b1;
              status_d = ffa_pkg::STS_BAD_CFG;
            end
          end
          ffa_pkg::CMD_ALLOC: ;
          ffa_pkg::CMD_STATS: begin
            if (n_q == '0) begin
              done_d = 1'b1;
            end
          end
          default: begin
            if (n_q == '0) begin
              done_d   = 1'b1;
              status_d = ffa_pkg::STS_NO_HANDLE;
            end
          end
        endcase
      end
      ffa_pkg::S_INIT_CHK: begin
        // Memory size must be a whole number of pages.
        if (want_q >= {1'b0, msize_q}) begin
          if (want_q != {1'b0, msize_q}) begin
            done_d   = 1'b1;
            status_d = ffa_pkg::STS_BAD_CFG;
          end
        end else begin
          want_d = want_q + {1'b0, page_q};
        end
      end
      ffa_pkg::S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[AW-1:0];
        mem_wdata = ibyte_q;
        cnt_d     = cnt_q + LW'(1);
      end
      ffa_pkg::S_INIT_SEG: begin
        seg_we           = 1'b1;
        seg_waddr        = '0;
        seg_wdata.start  = '0;
        seg_wdata.len    = msize_q;
        seg_wdata.alloc  = 1'b0;
        seg_wdata.owner  = ffa_pkg::OWNER_NONE;
        seg_wdata.cursor = '0;
        n_d              = SCW'(1);
        done_d           = 1'b1;
      end
      ffa_pkg::S_HOLD_CHK: begin
        if (rd.alloc && (rd.owner == {1'b0, item_q.task_id})) begin
          done_d   = 1'b1;
          status_d = ffa_pkg::STS_HOLDS;
        end else begin
          idx_d = idx_q + SCW'(1);
        end
      end
      ffa_pkg::S_ALLOC_CHK: begin
        want_d = '0;
        if (page_q == '0) begin
          done_d   = 1'b1;
          status_d = ffa_pkg::STS_BAD_CFG;
        end else if (item_q.req_size == '0) begin
          done_d   = 1'b1;
          status_d = ffa_pkg::STS_RANGE;
        end
      end
      ffa_pkg::S_WANT: begin
        // Round the request up to whole pages by repeated addition.
        if (want_q >= {1'b0, item_q.req_size}) begin
          idx_d = '0;
          if (n_q == '0) begin
            done_d   = 1'b1;
            status_d = ffa_pkg::STS_NO_SPACE;
          end
        end else begin
          want_d = want_q + {1'b0, page_q};
        end
      end
      ffa_pkg::S_FIT_CHK: begin
        if (fit_ok) begin
          ent_d   = rd;
          found_d = idx_q;
          if (split && (n_q == SCW'(ffa_pkg::MAX_SEG))) begin
            done_d   = 1'b1;
            status_d = ffa_pkg::STS_NO_SPACE;
          end else if (split && (n_q > idx_q + SCW'(1))) begin
            idx_d = n_q;
          end
        end else begin
          idx_d = idx_q + SCW'(1);
          if (last_idx) begin
            done_d   = 1'b1;
            status_d = ffa_pkg::STS_NO_SPACE;
          end
        end
      end
      ffa_pkg::S_UP_RD: begin
        seg_raddr = SIW'(idx_q - SCW'(1));
      end
      ffa_pkg::S_UP_WR: begin
        seg_we    = 1'b1;
        seg_waddr = idx_q[SIW-1:0];
        seg_wdata = rd;
        idx_d     = idx_q - SCW'(1);
      end
      ffa_pkg::S_SPLIT_WR: begin
        seg_we    = 1'b1;
        seg_waddr = SIW'(found_q + SCW'(1));
        seg_wdata = split_ent;
        n_d       = n_q + SCW'(1);
      end
      ffa_pkg::S_TAKE_WR: begin
        seg_we    = 1'b1;
        seg_wdata = take_ent;
        done_d    = 1'b1;
        data_d    = ffa_pkg::DATA_W'(ent_q.start);
      end
      ffa_pkg::S_FIND_CHK: begin
        if (rd.start == AW'(item_q.handle)) begin
          ent_d   = rd;
          found_d = idx_q;
        end else begin
          idx_d = idx_q + SCW'(1);
          if (last_idx) begin
            done_d   = 1'b1;
            status_d = ffa_pkg::STS_NO_HANDLE;
          end
        end
      end
      ffa_pkg::S_ACCESS: begin
        if (!owner_ok) begin
          done_d   = 1'b1;
          status_d = ffa_pkg::STS_NOT_OWNER;
        end else begin
          case (item_q.cmd)
            ffa_pkg::CMD_FREE: begin
              has_prev_d = 1'b0;
              has_next_d = 1'b0;
            end
            ffa_pkg::CMD_RNEXT, ffa_pkg::CMD_WNEXT: begin
              seg_we    = 1'b1;
              seg_wdata = cur_ent;
              if (cur_end) begin
                done_d   = 1'b1;
                status_d = ffa_pkg::STS_RANGE;
              end else if (item_q.cmd == ffa_pkg::CMD_WNEXT) begin
                mem_we = 1'b1;
                done_d = 1'b1;
              end
            end
            ffa_pkg::CMD_RAT, ffa_pkg::CMD_WAT: begin
              if (at_bad) begin
                done_d   = 1'b1;
                status_d = ffa_pkg::STS_RANGE;
              end else if (item_q.cmd == ffa_pkg::CMD_WAT) begin
                mem_we = 1'b1;
                done_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ffa_pkg::S_MEM_RD: begin
        done_d = 1'b1;
        data_d = ffa_pkg::DATA_W'(mem_rdata);
      end
      ffa_pkg::S_PREV_RD: begin
        seg_raddr = SIW'(found_q - SCW'(1));
      end
      ffa_pkg::S_PREV_CHK: begin
        prev_d     = rd;
        has_prev_d = !rd.alloc;
      end
      ffa_pkg::S_NEXT_RD: begin
        seg_raddr = SIW'(found_q + SCW'(1));
      end
      ffa_pkg::S_NEXT_CHK: begin
        nxt_len_d  = rd.len;
        has_next_d = !rd.alloc;
      end
      ffa_pkg::S_MERGE_WR: begin
        // Freed segment absorbs its free neighbors.
        seg_we    = 1'b1;
        seg_waddr = base_idx[SIW-1:0];
        seg_wdata = merge_ent;
        idx_d     = base_idx + SCW'(1);
        if ((base_idx + SCW'(1) + SCW'(del)) >= n_q) begin
          n_d   = n_q - SCW'(del);
          idx_d = '0;
        end
      end
      ffa_pkg::S_DN_RD: begin
        seg_raddr = SIW'(idx_q + SCW'(del));
      end
      ffa_pkg::S_DN_WR: begin
        seg_we    = 1'b1;
        seg_waddr = idx_q[SIW-1:0];
        seg_wdata = rd;
        idx_d     = idx_q + SCW'(1);
        if ((idx_q + SCW'(1) + SCW'(del)) >= n_q) begin
          n_d   = n_q - SCW'(del);
          idx_d = '0;
        end
      end
      ffa_pkg::S_DOT_CHK: begin
        if (!rd.alloc) begin
          ent_d = rd;
          cnt_d = '0;
        end else begin
          idx_d = idx_q + SCW'(1);
          if (last_idx) begin
            done_d = 1'b1;
          end
        end
      end
      ffa_pkg::S_DOT_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = ent_q.start + cnt_q[AW-1:0];
        mem_wdata = ffa_pkg::DOT_CHAR;
        cnt_d     = cnt_q + LW'(1);
        if ((cnt_q + LW'(1)) >= ent_q.len) begin
          idx_d = idx_q + SCW'(1);
          if (last_idx) begin
            done_d = 1'b1;
          end
        end
      end
      ffa_pkg::S_STAT_CHK: begin
        if (!rd.alloc) begin
          ftot_d = ftot_q + rd.len;
          if (rd.len > large_q) begin
            large_d = rd.len;
          end
          if ((small_q == '0) || (rd.len < small_q)) begin
            small_d = rd.len;
          end
        end
        idx_d = idx_q + SCW'(1);
        if (last_idx) begin
          done_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    if (done_d) begin
      state_d = ffa_pkg::S_IDLE;
    end else begin
      case (state_q)
        ffa_pkg::S_IDLE: begin
          if (q_valid_i) begin
            state_d = ffa_pkg::S_DISP;
          end
        end
        ffa_pkg::S_DISP: begin
          case (item_q.cmd)
            ffa_pkg::CMD_INIT:  state_d = ffa_pkg::S_INIT_CHK;
            ffa_pkg::CMD_ALLOC: state_d = (n_q == '0) ? ffa_pkg::S_ALLOC_CHK
                                                      : ffa_pkg::S_HOLD_RD;
            ffa_pkg::CMD_STATS: state_d = ffa_pkg::S_STAT_RD;
            default:            state_d = ffa_pkg::S_FIND_RD;
          endcase
        end
        ffa_pkg::S_INIT_CHK: begin
          if (want_q >= {1'b0, msize_q}) begin
            state_d = ffa_pkg::S_FILL;
          end
        end
        ffa_pkg::S_FILL: begin
          if ((cnt_q + LW'(1)) >= msize_q) begin
            state_d = ffa_pkg::S_INIT_SEG;
          end
        end
        ffa_pkg::S_HOLD_RD:   state_d = ffa_pkg::S_HOLD_CHK;
        ffa_pkg::S_HOLD_CHK:  state_d = last_idx ? ffa_pkg::S_ALLOC_CHK : ffa_pkg::S_HOLD_RD;
        ffa_pkg::S_ALLOC_CHK: state_d = ffa_pkg::S_WANT;
        ffa_pkg::S_WANT: begin
          if (want_q >= {1'b0, item_q.req_size}) begin
            state_d = ffa_pkg::S_FIT_RD;
          end
        end
        ffa_pkg::S_FIT_RD: state_d = ffa_pkg::S_FIT_CHK;
        ffa_pkg::S_FIT_CHK: begin
          if (fit_ok) begin
            if (!split) begin
              state_d = ffa_pkg::S_TAKE_WR;
            end else if (n_q > idx_q + SCW'(1)) begin
              state_d = ffa_pkg::S_UP_RD;
            end else begin
              state_d = ffa_pkg::S_SPLIT_WR;
            end
          end else begin
            state_d = ffa_pkg::S_FIT_RD;
          end
        end
        ffa_pkg::S_UP_RD: state_d = ffa_pkg::S_UP_WR;
        ffa_pkg::S_UP_WR: begin
          state_d = ((idx_q - SCW'(1)) > (found_q + SCW'(1))) ? ffa_pkg::S_UP_RD
                                                             : ffa_pkg::S_SPLIT_WR;
        end
        ffa_pkg::S_SPLIT_WR: state_d = ffa_pkg::S_TAKE_WR;
        ffa_pkg::S_FIND_RD:  state_d = ffa_pkg::S_FIND_CHK;
        ffa_pkg::S_FIND_CHK: begin
          state_d = (rd.start == AW'(item_q.handle)) ? ffa_pkg::S_ACCESS
                                                     : ffa_pkg::S_FIND_RD;
        end
        ffa_pkg::S_ACCESS: begin
          if (item_q.cmd == ffa_pkg::CMD_FREE) begin
            if (found_q != '0) begin
              state_d = ffa_pkg::S_PREV_RD;
            end else if ((found_q + SCW'(1)) < n_q) begin
              state_d = ffa_pkg::S_NEXT_RD;
            end else begin
              state_d = ffa_pkg::S_MERGE_WR;
            end
          end else begin
            state_d = ffa_pkg::S_MEM_RD;
          end
        end
        ffa_pkg::S_PREV_RD: state_d = ffa_pkg::S_PREV_CHK;
        ffa_pkg::S_PREV_CHK: begin
          state_d = ((found_q + SCW'(1)) < n_q) ? ffa_pkg::S_NEXT_RD
                                                : ffa_pkg::S_MERGE_WR;
        end
        ffa_pkg::S_NEXT_RD:  state_d = ffa_pkg::S_NEXT_CHK;
        ffa_pkg::S_NEXT_CHK: state_d = ffa_pkg::S_MERGE_WR;
        ffa_pkg::S_MERGE_WR: begin
          state_d = ((base_idx + SCW'(1) + SCW'(del)) >= n_q) ? ffa_pkg::S_DOT_RD
                                                              : ffa_pkg::S_DN_RD;
        end
        ffa_pkg::S_DN_RD: state_d = ffa_pkg::S_DN_WR;
        ffa_pkg::S_DN_WR: begin
          state_d = ((idx_q + SCW'(1) + SCW'(del)) >= n_q) ? ffa_pkg::S_DOT_RD
                                                           : ffa_pkg::S_DN_RD;
        end
        ffa_pkg::S_DOT_RD:  state_d = ffa_pkg::S_DOT_CHK;
        ffa_pkg::S_DOT_CHK: state_d = !rd.alloc ? ffa_pkg::S_DOT_FILL : ffa_pkg::S_DOT_RD;
        ffa_pkg::S_DOT_FILL: begin
          if ((cnt_q + LW'(1)) >= ent_q.len) begin
            state_d = ffa_pkg::S_DOT_RD;
          end
        end
        ffa_pkg::S_STAT_RD:  state_d = ffa_pkg::S_STAT_CHK;
        ffa_pkg::S_STAT_CHK: state_d = ffa_pkg::S_STAT_RD;
        default:             state_d = ffa_pkg::S_IDLE;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffa_pkg::S_IDLE;
      n_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      done_q  <= done_d;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    ent_q      <= ent_d;
    prev_q     <= prev_d;
    status_q   <= status_d;
    idx_q      <= idx_d;
    found_q    <= found_d;
    want_q     <= want_d;
    cnt_q      <= cnt_d;
    nxt_len_q  <= nxt_len_d;
    has_prev_q <= has_prev_d;
    has_next_q <= has_next_d;
    data_q     <= data_d;
    ftot_q     <= ftot_d;
    large_q    <= large_d;
    small_q    <= small_d;
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign data_out_o      = data_q;
  assign free_total_o    = ftot_q;
  assign largest_free_o  = large_q;
  assign smallest_free_o = small_q;

endmodule
`default_nettype wire

### hw/rtl/first_fit_segment_allocator_top.sv
`default_nettype none
// First-fit segment allocator over a 1024-byte memory with up to 64 segments.
// A command is taken when start is high and busy is low; a two-beat queue
// sits in front of the sequencer, so busy rises only when two commands wait.
// Each command gives one result beat, shown for one cycle with done high, and
// the receiver cannot stall it. Commands run one at a time on a sequencer
// that walks the segment table RAM entry by entry. Read and write accesses
// and stats walk the table; alloc also rounds the request up page by page
// and shifts later entries when it splits, free also merges neighbors and
// fills every free byte with a dot, and init steps through the pages and
// then fills every byte of the configured memory size. The user must write
// registers through the cfg port only while no command is in flight; the block itself does not enforce this.
module first_fit_segment_allocator_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ffa_pkg::CIDX_W-1:0]    cfg_idx_i,
  input  wire logic [ffa_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [ffa_pkg::CMD_W-1:0]     cmd_i,
  input  wire logic [ffa_pkg::TASK_BITS-1:0] task_id_i,
  input  wire logic [ffa_pkg::HDL_W-1:0]     handle_i,
  input  wire logic [ffa_pkg::SIZE_W-1:0]    req_size_i,
  input  wire logic [ffa_pkg::HDL_W-1:0]     offset_i,
  input  wire logic [ffa_pkg::SIZE_W-1:0]    span_i,
  input  wire logic [ffa_pkg::BYTE_W-1:0]    byte_in_i,
  output logic                               done_o,
  output logic [ffa_pkg::STS_W-1:0]          status_o,
  output logic [ffa_pkg::DATA_W-1:0]         data_out_o,
  output logic [ffa_pkg::SIZE_W-1:0]         free_total_o,
  output logic [ffa_pkg::SIZE_W-1:0]         largest_free_o,
  output logic [ffa_pkg::SIZE_W-1:0]         smallest_free_o
);

  logic           q_valid;
  logic           q_pop;
  ffa_pkg::item_t q_item;

  // Command intake and queue.
  ffa_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .task_id_i  (task_id_i),
    .handle_i   (handle_i),
    .req_size_i (req_size_i),
    .offset_i   (offset_i),
    .span_i     (span_i),
    .byte_in_i  (byte_in_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  // Command sequencer with segment table and byte memory.
  ffa_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .q_valid_i       (q_valid),
    .q_item_i        (q_item),
    .q_pop_o         (q_pop),
    .done_o          (done_o),
    .status_o        (status_o),
    .data_out_o      (data_out_o),
    .free_total_o    (free_total_o),
    .largest_free_o  (largest_free_o),
    .smallest_free_o (smallest_free_o)
  );

endmodule
`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps
module tb;
  import ffa_pkg::*;

  // One result beat as seen on the result ports.
  typedef struct packed {
    status_e             status;
    logic [DATA_W-1:0]   data;
    logic [SIZE_W-1:0]   free_total;
    logic [SIZE_W-1:0]   largest;
    logic [SIZE_W-1:0]   smallest;
  } result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CIDX_W-1:0]    cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [CMD_W-1:0]     cmd = '0;
  logic [TASK_BITS-1:0] task_id = '0;
  logic [HDL_W-1:0]     handle = '0;
  logic [SIZE_W-1:0]    req_size = '0;
  logic [HDL_W-1:0]     offset = '0;
  logic [SIZE_W-1:0]    span = '0;
  logic [BYTE_W-1:0]    byte_in = '0;
  logic                 done_o;
  logic [STS_W-1:0]     status_o;
  logic [DATA_W-1:0]    data_out_o;
  logic [SIZE_W-1:0]    free_total_o;
  logic [SIZE_W-1:0]    largest_free_o;
  logic [SIZE_W-1:0]    smallest_free_o;

  first_fit_segment_allocator_top u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .start(start), .busy(busy),
    .cmd_i(cmd), .task_id_i(task_id), .handle_i(handle), .req_size_i(req_size),
    .offset_i(offset), .span_i(span), .byte_in_i(byte_in),
    .done_o(done_o), .status_o(status_o), .data_out_o(data_out_o),
    .free_total_o(free_total_o), .largest_free_o(largest_free_o),
    .smallest_free_o(smallest_free_o)
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the allocator state.
  logic [SIZE_W-1:0] pg_size;
  logic [SIZE_W-1:0] m_size;
  logic [BYTE_W-1:0] i_byte;
  logic [BYTE_W-1:0] mem_shadow [MEM_BYTES];
  logic              sg_used  [MAX_SEG];
  logic [AW-1:0]     sg_start [MAX_SEG];
  logic [LW-1:0]     sg_len   [MAX_SEG];
  logic              sg_alloc [MAX_SEG];
  logic [OW-1:0]     sg_owner [MAX_SEG];
  logic [LW-1:0]     sg_cur   [MAX_SEG];

  item_t   cmd_pending [$];
  result_t result_due  [$];
  int      mismatches = 0;
  bit      quiet = 1'b0;
  int      gap = 0;

  function automatic int seg_total();
    int n;
    n = 0;
    while (n < MAX_SEG && sg_used[n]) n++;
    return n;
  endfunction

  function automatic void seg_wipe(int k);
    sg_used[k] = 1'b0;
    sg_start[k] = '0;
    sg_len[k] = '0;
    sg_alloc[k] = 1'b0;
    sg_owner[k] = OWNER_NONE;
    sg_cur[k] = '0;
  endfunction

  function automatic void seg_move(int d, int s);
    sg_used[d] = sg_used[s];
    sg_start[d] = sg_start[s];
    sg_len[d] = sg_len[s];
    sg_alloc[d] = sg_alloc[s];
    sg_owner[d] = sg_owner[s];
    sg_cur[d] = sg_cur[s];
  endfunction

  // Merge neighboring free segments, then fill every free byte with a dot.
  function automatic void coalesce();
    int n, i, k, b;
    n = seg_total();
    i = 0;
    while (i + 1 < n) begin
      if (!sg_alloc[i] && !sg_alloc[i+1]) begin
        sg_len[i] = sg_len[i] + sg_len[i+1];
        for (k = i + 1; k + 1 < n; k++) seg_move(k, k + 1);
        seg_wipe(n - 1);
        n--;
      end else begin
        i++;
      end
    end
    for (i = 0; i < n; i++)
      if (!sg_alloc[i])
        for (b = 0; b < sg_len[i]; b++)
          if (sg_start[i] + b < MEM_BYTES) mem_shadow[sg_start[i] + b] = DOT_CHAR;
  endfunction

  // Apply one command to the shadow state and return its result beat.
  function automatic result_t run_command(item_t it);
    result_t r;
    int n, i, k, s, want;
    bit holds;
    r = '0;
    r.status = STS_OK;
    n = seg_total();
    case (it.cmd)
      CMD_INIT: begin
        if (pg_size == 0 || m_size == 0 || pg_size > m_size || m_size > MEM_BYTES ||
            (m_size % pg_size) != 0) begin
          r.status = STS_BAD_CFG;
        end else begin
          for (i = 0; i < m_size; i++) mem_shadow[i] = i_byte;
          for (k = 0; k < MAX_SEG; k++) seg_wipe(k);
          sg_used[0] = 1'b1;
          sg_len[0] = m_size;
        end
      end
      CMD_ALLOC: begin
        holds = 1'b0;
        for (i = 0; i < n; i++)
          if (sg_alloc[i] && sg_owner[i] == {1'b0, it.task_id}) holds = 1'b1;
        if (holds) r.status = STS_HOLDS;
        else if (pg_size == 0) r.status = STS_BAD_CFG;
        else if (it.req_size == 0) r.status = STS_RANGE;
        else begin
          want = ((int'(it.req_size) + pg_size - 1) / pg_size) * pg_size;
          r.status = STS_NO_SPACE;
          for (i = 0; i < n; i++) begin
            if (sg_alloc[i] || sg_len[i] < want) continue;
            if (sg_len[i] > want) begin
              if (n >= MAX_SEG) break;
              for (k = n; k > i + 1; k--) seg_move(k, k - 1);
              seg_wipe(i + 1);
              sg_used[i+1] = 1'b1;
              sg_start[i+1] = sg_start[i] + AW'(want);
              sg_len[i+1] = sg_len[i] - LW'(want);
              sg_len[i] = LW'(want);
            end
            sg_alloc[i] = 1'b1;
            sg_owner[i] = {1'b0, it.task_id};
            sg_cur[i] = '0;
            r.status = STS_OK;
            r.data = sg_start[i];
            break;
          end
        end
      end
      CMD_STATS: begin
        for (i = 0; i < n; i++) begin
          if (sg_alloc[i]) continue;
          r.free_total = r.free_total + sg_len[i];
          if (sg_len[i] > r.largest) r.largest = sg_len[i];
          if (r.smallest == 0 || sg_len[i] < r.smallest) r.smallest = sg_len[i];
        end
      end
      default: begin
        s = -1;
        for (i = 0; i < n; i++)
          if (s < 0 && sg_start[i] == it.handle) s = i;
        if (s < 0) r.status = STS_NO_HANDLE;
        else if (!sg_alloc[s] || sg_owner[s] != {1'b0, it.task_id}) r.status = STS_NOT_OWNER;
        else if (it.cmd == CMD_FREE) begin
          sg_alloc[s] = 1'b0;
          sg_owner[s] = OWNER_NONE;
          sg_cur[s] = '0;
          coalesce();
        end else if (it.cmd == CMD_RNEXT || it.cmd == CMD_WNEXT) begin
          if (sg_cur[s] >= sg_len[s]) begin
            sg_cur[s] = '0;
            r.status = STS_RANGE;
          end else begin
            if (it.cmd == CMD_RNEXT)
              r.data = DATA_W'(mem_shadow[sg_start[s] + sg_cur[s]]);
            else mem_shadow[sg_start[s] + sg_cur[s]] = it.byte_in;
            sg_cur[s] = sg_cur[s] + LW'(1);
          end
        end else begin
          if (it.offset >= sg_len[s] || int'(it.offset) + int'(it.span) > sg_len[s])
            r.status = STS_RANGE;
          else if (it.cmd == CMD_RAT)
            r.data = DATA_W'(mem_shadow[sg_start[s] + it.offset]);
          else mem_shadow[sg_start[s] + it.offset] = it.byte_in;
        end
      end
    endcase
    return r;
  endfunction

  // Queue a command and the result that the shadow state predicts for it.
  task automatic issue(cmd_e c, int t, int h = 0, int sz = 1, int off = 0, int sp = 1,
                       int b = 0);
    item_t it;
    it.cmd = c;
    it.task_id = TASK_BITS'(t);
    it.handle = HDL_W'(h);
    it.req_size = SIZE_W'(sz);
    it.offset = HDL_W'(off);
    it.span = SIZE_W'(sp);
    it.byte_in = BYTE_W'(b);
    result_due.push_back(run_command(it));
    cmd_pending.push_back(it);
  endtask

  // One random command, mostly aimed at segments that are really owned.
  task automatic issue_random(int tmax);
    int r, t, h, sz, off, sp, pick, len;
    int owned [$];
    cmd_e c;
    r = $urandom_range(0, 99);
    for (int i = 0; i < seg_total(); i++) if (sg_alloc[i]) owned.push_back(i);
    if (r < 2) c = CMD_INIT;
    else if (r < 30) c = CMD_ALLOC;
    else if (r < 42) c = CMD_FREE;
    else if (r < 56) c = CMD_RNEXT;
    else if (r < 68) c = CMD_WNEXT;
    else if (r < 78) c = CMD_RAT;
    else if (r < 88) c = CMD_WAT;
    else if (r < 94) c = CMD_STATS;
    else c = cmd_e'($urandom_range(1, 7));
    t = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, tmax);
    h = $urandom_range(0, 1023);
    off = $urandom_range(0, 1023);
    sp = $urandom_range(1, 1024);
    r = $urandom_range(0, 19);
    if (r < 14) sz = $urandom_range(1, (pg_size > 0 && pg_size < 342) ? 3 * pg_size : 64);
    else if (r < 18) sz = $urandom_range(1, 1024);
    else if (r < 19) sz = 0;
    else sz = 1024;
    if (c != CMD_ALLOC && owned.size() > 0 && $urandom_range(0, 99) < 85) begin
      pick = owned[$urandom_range(0, owned.size() - 1)];
      h = int'(sg_start[pick]);
      t = int'(sg_owner[pick][TASK_BITS-1:0]);
      len = int'(sg_len[pick]);
      if ($urandom_range(0, 4) != 0) begin
        off = $urandom_range(0, (len > 1024 ? 1024 : len) - 1);
        sp = $urandom_range(1, len - off);
      end
    end else if (c != CMD_ALLOC && $urandom_range(0, 1) == 0) begin
      h = int'(sg_start[$urandom_range(0, MAX_SEG - 1)]);
    end
    issue(c, t, h, sz, off, sp, $urandom_range(0, 255));
  endtask

  task automatic settle();
    while (cmd_pending.size() != 0 || start || result_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_config(int pg, int ms, int ib);
    pg_size = SIZE_W'(pg);
    m_size = SIZE_W'(ms);
    i_byte = BYTE_W'(ib);
    @(posedge clk_i);
    cfg_we <= 1'b1; cfg_idx <= CFG_PAGE; cfg_data <= CFG_W'(pg);
    @(posedge clk_i);
    cfg_idx <= CFG_MSIZE; cfg_data <= CFG_W'(ms);
    @(posedge clk_i);
    cfg_idx <= CFG_IBYTE; cfg_data <= CFG_W'(ib);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Driver: present the next queued command, with random idle bursts.
  always @(posedge clk_i) begin
    item_t nx;
    if (!start || !busy) begin
      if (gap > 0) begin
        gap <= gap - 1;
        start <= 1'b0;
      end else if (cmd_pending.size() > 0) begin
        nx = cmd_pending.pop_front();
        start <= 1'b1;
        cmd <= nx.cmd; task_id <= nx.task_id; handle <= nx.handle;
        req_size <= nx.req_size; offset <= nx.offset; span <= nx.span;
        byte_in <= nx.byte_in;
        if (!quiet && $urandom_range(0, 7) == 0) gap <= $urandom_range(1, 13);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check each result beat against the oldest prediction.
  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && done_o) begin
      if (result_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat, status %0d", status_o);
      end else begin
        exp_r = result_due.pop_front();
        if (status_o !== exp_r.status || data_out_o !== exp_r.data ||
            free_total_o !== exp_r.free_total || largest_free_o !== exp_r.largest ||
            smallest_free_o !== exp_r.smallest) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp sts %0d data %0d tot %0d big %0d sml %0d, got %0d %0d %0d %0d %0d",
                     exp_r.status, exp_r.data, exp_r.free_total, exp_r.largest,
                     exp_r.smallest, status_o, data_out_o, free_total_o,
                     largest_free_o, smallest_free_o);
        end
      end
    end
  end

  initial begin
    #100ms;
    $display("FAIL first_fit_segment_allocator_top");
    $finish;
  end

  initial begin
    pg_size = 16; m_size = 1024; i_byte = 0;
    for (int a = 0; a < MEM_BYTES; a++) mem_shadow[a] = '0;
    for (int k = 0; k < MAX_SEG; k++) seg_wipe(k);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Before any init there are no segments.
    issue(CMD_ALLOC, 1, 0, 16);
    issue(CMD_FREE, 1, 0);
    issue(CMD_STATS, 0);
    settle();

    // Default sizes: the common error paths and a free that merges.
    set_config(16, 1024, 8'h00);
    issue(CMD_INIT, 0);
    issue(CMD_ALLOC, 1, 0, 0);
    issue(CMD_ALLOC, 1, 0, 1);
    issue(CMD_ALLOC, 1, 0, 5);
    issue(CMD_ALLOC, 2, 0, 1024);
    issue(CMD_ALLOC, 255, 0, 17);
    issue(CMD_WAT, 1, 0, 1, 0, 16, 8'hFF);
    issue(CMD_RAT, 1, 0, 1, 0, 16);
    issue(CMD_RAT, 1, 0, 1, 15, 2);
    issue(CMD_RAT, 1, 0, 1, 16, 1);
    issue(CMD_WNEXT, 1, 0, 1, 0, 1, 8'h55);
    issue(CMD_RNEXT, 1, 0);
    issue(CMD_RNEXT, 2, 0);
    issue(CMD_FREE, 2, 0);
    issue(CMD_FREE, 1, 5);
    issue(CMD_FREE, 1, 0);
    issue(CMD_RNEXT, 1, 0);
    issue(CMD_STATS, 0);
    issue(CMD_FREE, 255, 16);
    issue(CMD_STATS, 0);
    repeat (200) issue_random(15);
    settle();

    // One-byte pages: cursor wrap and a full segment table.
    set_config(1, 64, 8'hFF);
    issue(CMD_INIT, 0);
    issue(CMD_ALLOC, 3, 0, 2);
    issue(CMD_WNEXT, 3, 0, 1, 0, 1, 8'h01);
    issue(CMD_WNEXT, 3, 0, 1, 0, 1, 8'hFE);
    issue(CMD_WNEXT, 3, 0, 1, 0, 1, 8'h77);
    issue(CMD_RNEXT, 3, 0);
    issue(CMD_RNEXT, 3, 0);
    repeat (100) issue_random(90);
    settle();

    set_config(1024, 1024, 8'hA5);
    issue(CMD_INIT, 0);
    repeat (50) issue_random(3);
    settle();

    set_config(8, 1000, 8'h5A);
    issue(CMD_INIT, 0);
    repeat (120) issue_random(20);
    settle();

    // Refused configurations leave the old segments in place.
    set_config(0, 1024, 8'h11);
    issue(CMD_INIT, 0);
    repeat (10) issue_random(20);
    settle();
    set_config(16, 0, 8'h22);
    issue(CMD_INIT, 0);
    settle();
    set_config(32, 16, 8'h33);
    issue(CMD_INIT, 0);
    settle();
    set_config(24, 1000, 8'h44);
    issue(CMD_INIT, 0);
    repeat (10) issue_random(20);
    settle();
    set_config(1, 2047, 8'h66);
    issue(CMD_INIT, 0);
    settle();

    // Last stretch runs back to back.
    set_config(16, 1024, 8'h3C);
    quiet = 1'b1;
    issue(CMD_INIT, 0);
    repeat (200) issue_random(12);
    settle();
    repeat (50) @(posedge clk_i);

    if (mismatches == 0 && result_due.size() == 0) begin
      $display("PASS first_fit_segment_allocator_top");
    end else begin
      $display("FAIL first_fit_segment_allocator_top");
    end
    $finish;
  end

endmodule
